@@ design/wacrm_pkg.sv @@
// Package for the windowed AC RMS meter: payload structs, register codes and reset values.
// No dependencies; the front, back, top and checker files use it by scoped names.
package wacrm_pkg;

  // register indexes of the configuration port
  localparam logic [0:0] CFG_WINDOWS = 1'd0;
  localparam logic [0:0] CFG_GAIN    = 1'd1;

  localparam int unsigned CFG_DATA_W   = 20;
  localparam int unsigned WIN_W        = 8;
  localparam int unsigned GAIN_W       = 20;
  localparam int unsigned FIELD_W      = 12;
  localparam logic [WIN_W-1:0]  WIN_RESET  = 8'd5;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd46475;
  localparam logic [FIELD_W-1:0] OUT_MAX   = 12'd4095;

  typedef struct packed {
    logic [FIELD_W-1:0] sample;
    logic               window_end;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] rms_reading;
    logic [FIELD_W-1:0] zero_point;
    logic               overflow;
  } out_t;

  // classification of a finished window, front to back
  typedef struct packed {
    logic is_offset;
    logic last;
    logic overflow;
  } win_ctl_t;

  localparam int unsigned CTL_W = $bits(win_ctl_t);

endpackage

@@ design/wacrm_fifo.sv @@
// Short register queue between the sample front and the window back end.
// Depends on nothing; width and depth come from parameters.
module wacrm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  // store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

@@ design/wacrm_front.sv @@
// Sample front: accumulates samples or squared deviations per window and hands finished
// windows to the back end. Depends on wacrm_pkg.
module wacrm_front #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned SUM_W       = 2 * SAMPLE_BITS + COUNT_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  wacrm_pkg::in_t             in_i,
  input  logic [wacrm_pkg::WIN_W-1:0] windows_i,
  output logic                       rec_wr_o,
  input  logic                       rec_full_i,
  output logic [SUM_W-1:0]           rec_sum_o,
  output logic [COUNT_BITS-1:0]      rec_cnt_o,
  output logic [wacrm_pkg::WIN_W-1:0] rec_done_o,
  output logic [SAMPLE_BITS-1:0]     rec_dc_o,
  output wacrm_pkg::win_ctl_t        rec_ctl_o,
  input  logic                       dc_valid_i,
  input  logic [SAMPLE_BITS-1:0]     dc_i
);
  localparam int unsigned W = wacrm_pkg::WIN_W;

  logic                   meas_q, ovf_q, wait_dc_q;
  logic [W-1:0]           win_idx_q;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] dc_q, s, d;
  logic [15:0]            s_ext;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic                   accept, at_max, ovf_d, is_last;
  logic [W:0]             done;
  logic [W-1:0]           target;

  assign full   = rec_full_i | wait_dc_q;
  assign accept = push & ~full;

  // deviation from the zero point and its square
  assign s_ext = 16'(in_i.sample);
  assign s     = s_ext[SAMPLE_BITS-1:0];
  assign d     = (s >= dc_q) ? s - dc_q : dc_q - s;
  assign sq    = d * d;

  // stop counting at the limit, flag overflow
  assign at_max = (cnt_q == '1);
  assign ovf_d  = ovf_q | at_max;
  assign cnt_d  = at_max ? cnt_q : cnt_q + 1'b1;
  assign sum_d  = at_max ? sum_q :
                  (meas_q ? sum_q + SUM_W'(sq) : sum_q + SUM_W'(s));

  // classify the window end
  assign done    = {1'b0, win_idx_q} + 1'b1;
  assign target  = (windows_i == '0) ? W'(1) : windows_i;
  assign is_last = meas_q && (done >= {1'b0, target});

  assign rec_wr_o   = accept & in_i.window_end;
  assign rec_sum_o  = sum_d;
  assign rec_cnt_o  = cnt_d;
  assign rec_done_o = done[W-1:0];
  assign rec_dc_o   = dc_q;
  assign rec_ctl_o  = '{is_offset: ~meas_q, last: is_last, overflow: ovf_d};

  // window bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_q    <= 1'b0;
      ovf_q     <= 1'b0;
      wait_dc_q <= 1'b0;
      win_idx_q <= '0;
      cnt_q     <= '0;
      sum_q     <= '0;
      dc_q      <= '0;
    end else begin
      if (dc_valid_i) begin
        dc_q      <= dc_i;
        wait_dc_q <= 1'b0;
      end
      if (accept) begin
        if (!in_i.window_end) begin
          cnt_q <= cnt_d;
          sum_q <= sum_d;
          ovf_q <= ovf_d;
        end else begin
          cnt_q <= '0;
          sum_q <= '0;
          if (!meas_q) begin
            meas_q    <= 1'b1;
            win_idx_q <= '0;
            wait_dc_q <= 1'b1;
            ovf_q     <= ovf_d;
          end else if (is_last) begin
            meas_q    <= 1'b0;
            win_idx_q <= '0;
            ovf_q     <= 1'b0;
          end else begin
            win_idx_q <= done[W-1:0];
            ovf_q     <= ovf_d;
          end
        end
      end
    end
  end
endmodule

@@ design/wacrm_back.sv @@
// Window back end: shared bit-serial divider, digit-serial square root, gain multiply and
// accumulation; returns the zero point to the front and fills the result register.
// Depends on wacrm_pkg.
module wacrm_back #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned SUM_W       = 2 * SAMPLE_BITS + COUNT_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rec_empty_i,
  output logic                        rec_rd_o,
  input  logic [SUM_W-1:0]            rec_sum_i,
  input  logic [COUNT_BITS-1:0]       rec_cnt_i,
  input  logic [wacrm_pkg::WIN_W-1:0] rec_done_i,
  input  logic [SAMPLE_BITS-1:0]      rec_dc_i,
  input  wacrm_pkg::win_ctl_t         rec_ctl_i,
  input  logic [wacrm_pkg::GAIN_W-1:0] gain_i,
  output logic                        dc_valid_o,
  output logic [SAMPLE_BITS-1:0]      dc_o,
  output logic                        empty,
  input  logic                        pop,
  output wacrm_pkg::out_t             out_o
);
  localparam int unsigned GW     = wacrm_pkg::GAIN_W;
  localparam int unsigned FW     = wacrm_pkg::FIELD_W;
  localparam int unsigned ROOT_W = SAMPLE_BITS + 8;
  localparam int unsigned SQ_W   = 2 * ROOT_W;
  localparam int unsigned PROD_W = ROOT_W + GW;
  localparam int unsigned SCL_W  = PROD_W - 16;
  localparam int unsigned ACC_W  = SCL_W + wacrm_pkg::WIN_W;
  localparam int unsigned DIV_W  = (SUM_W > ACC_W) ? SUM_W : ACC_W;
  localparam int unsigned DEN_W  = COUNT_BITS;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);
  localparam int unsigned AVG_W  = DIV_W - 8;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]             state_q, state_d;
  wacrm_pkg::win_ctl_t    ctl_q;
  logic [wacrm_pkg::WIN_W-1:0] done_q;
  logic [SAMPLE_BITS-1:0] dc_q;
  logic                   final_q;
  logic [DIV_W-1:0]       num_q;
  logic [DEN_W-1:0]       den_q;
  logic [DEN_W:0]         rem_q, div_r;
  logic                   div_ge;
  logic [STEP_W-1:0]      step_q;
  logic [SQ_W-1:0]        sv_q;
  logic [ROOT_W+1:0]      srem_q, s_r, s_t;
  logic [ROOT_W-1:0]      root_q;
  logic                   s_ge;
  logic [PROD_W-1:0]      prod_q;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [AVG_W-1:0]       avg;
  logic                   res_valid_q;
  wacrm_pkg::out_t        res_q;

  assign rec_rd_o = (state_q == ST_IDLE) && !rec_empty_i;
  assign empty    = ~res_valid_q;
  assign out_o    = res_q;
  assign dc_o     = num_q[SAMPLE_BITS-1:0];

  // one restoring divide step
  assign div_r  = {rem_q[DEN_W-1:0], num_q[DIV_W-1]};
  assign div_ge = div_r >= {1'b0, den_q};

  // one square root digit
  assign s_r  = {srem_q[ROOT_W-1:0], sv_q[SQ_W-1 -: 2]};
  assign s_t  = {root_q, 2'b01};
  assign s_ge = s_r >= s_t;

  assign acc_d = acc_q + ACC_W'(prod_q[PROD_W-1:16]);
  assign avg   = num_q[DIV_W-1:8];

  // sequence one window through the units
  always_comb begin
    state_d    = state_q;
    dc_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: if (!rec_empty_i) state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == STEP_W'(DIV_W)) begin
          if (final_q) begin
            state_d = ST_OUT;
          end else if (ctl_q.is_offset) begin
            dc_valid_o = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_SQRT;
          end
        end
      end
      ST_SQRT: if (step_q == STEP_W'(ROOT_W)) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = ctl_q.last ? ST_DIV : ST_IDLE;
      ST_OUT:  if (!res_valid_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      acc_q       <= '0;
      final_q     <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (pop && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          final_q <= 1'b0;
          step_q  <= '0;
        end
        ST_DIV: begin
          if (step_q == STEP_W'(DIV_W)) begin
            step_q <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_SQRT: begin
          step_q <= step_q + 1'b1;
        end
        ST_ACC: begin
          acc_q   <= acc_d;
          final_q <= ctl_q.last;
          step_q  <= '0;
        end
        ST_OUT: begin
          if (!res_valid_q) begin
            res_valid_q <= 1'b1;
            acc_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        ctl_q  <= rec_ctl_i;
        done_q <= rec_done_i;
        dc_q   <= rec_dc_i;
        num_q  <= DIV_W'(rec_sum_i);
        den_q  <= rec_cnt_i;
        rem_q  <= '0;
      end
      ST_DIV: begin
        if (step_q != STEP_W'(DIV_W)) begin
          rem_q <= div_ge ? div_r - {1'b0, den_q} : div_r;
          num_q <= {num_q[DIV_W-2:0], div_ge};
        end else begin
          if (den_q == '0) num_q <= '0;
          sv_q   <= {num_q[2*SAMPLE_BITS-1:0], 16'd0};
          srem_q <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        if (step_q != STEP_W'(ROOT_W)) begin
          srem_q <= s_ge ? s_r - s_t : s_r;
          root_q <= {root_q[ROOT_W-2:0], s_ge};
          sv_q   <= {sv_q[SQ_W-3:0], 2'b00};
        end
      end
      ST_MUL: begin
        prod_q <= PROD_W'(root_q) * PROD_W'(gain_i);
      end
      ST_ACC: begin
        num_q <= DIV_W'(acc_d);
        den_q <= DEN_W'(done_q);
        rem_q <= '0;
      end
      ST_OUT: begin
        if (!res_valid_q) begin
          res_q.rms_reading <= (avg > AVG_W'(wacrm_pkg::OUT_MAX)) ?
                               wacrm_pkg::OUT_MAX : avg[FW-1:0];
          res_q.zero_point  <= FW'(dc_q);
          res_q.overflow    <= ctl_q.overflow;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ design/windowed_ac_rms_meter_top.sv @@
// Top level of the windowed AC RMS meter: configuration registers, front, window queue, back.
// Depends on wacrm_pkg, wacrm_front, wacrm_fifo and wacrm_back.
//
// Use: push samples on in_i with push while full is low; set window_end on the last sample
// of each window. The first window of a measurement sets the zero point, the next
// windows_per_measurement windows are RMS windows; one reading appears on out_o
// (empty low) after the last of them and leaves with pop.
// Ordinary samples are taken every cycle while full is low. A window end queues the window
// for the back end (two-entry queue); full rises while the queue is full and, after the
// zero point window, until its divide is done. The divider is DIV_W bits wide, the larger
// of SUM_W = 2*SAMPLE_BITS+COUNT_BITS and the accumulator width, 40 bits by default.
// Each RMS window takes the back end through a bit-serial divide, a two-bit-per-cycle root
// and one multiply; the last window adds another divide. A reading is delayed while
// earlier windows still wait in the queue. A single result register holds the reading;
// if the receiver does not pop, the back end halts, the queue fills and full rises. Reset
// clears all measurement state, restores the register defaults (5 windows, gain 46475) and
// empties the queue and the result register. Configuration: cfg_we_i writes cfg_data_i to
// register cfg_idx_i. The user must write only while idle; the block has no check for it.
module windowed_ac_rms_meter_top #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  wacrm_pkg::in_t                   in_i,
  output logic                             empty,
  input  logic                             pop,
  output wacrm_pkg::out_t                  out_o,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [wacrm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  localparam int unsigned SUM_W = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned WW    = wacrm_pkg::WIN_W;
  localparam int unsigned REC_W = wacrm_pkg::CTL_W + SUM_W + COUNT_BITS + WW + SAMPLE_BITS;

  logic [WW-1:0]                   windows_q;
  logic [wacrm_pkg::GAIN_W-1:0]    gain_q;
  logic                            rec_wr, rec_full, rec_rd, rec_empty, dc_valid;
  logic [SUM_W-1:0]                f_sum, b_sum;
  logic [COUNT_BITS-1:0]           f_cnt, b_cnt;
  logic [WW-1:0]                   f_done, b_done;
  logic [SAMPLE_BITS-1:0]          f_dc, b_dc, dc;
  wacrm_pkg::win_ctl_t             f_ctl, b_ctl;
  logic [REC_W-1:0]                rec_in, rec_out;

  // hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      windows_q <= wacrm_pkg::WIN_RESET;
      gain_q    <= wacrm_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wacrm_pkg::CFG_WINDOWS: windows_q <= cfg_data_i[WW-1:0];
        wacrm_pkg::CFG_GAIN:    gain_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wacrm_front #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS), .SUM_W(SUM_W)) u_front (
    .clk_i, .rst_ni, .push, .full, .in_i,
    .windows_i (windows_q),
    .rec_wr_o  (rec_wr),
    .rec_full_i(rec_full),
    .rec_sum_o (f_sum),
    .rec_cnt_o (f_cnt),
    .rec_done_o(f_done),
    .rec_dc_o  (f_dc),
    .rec_ctl_o (f_ctl),
    .dc_valid_i(dc_valid),
    .dc_i      (dc)
  );

  assign rec_in = {f_ctl, f_sum, f_cnt, f_done, f_dc};

  wacrm_fifo #(.WIDTH(REC_W), .DEPTH(2)) u_queue (
    .clk_i, .rst_ni,
    .wr_i   (rec_wr),
    .wdata_i(rec_in),
    .full_o (rec_full),
    .rd_i   (rec_rd),
    .rdata_o(rec_out),
    .empty_o(rec_empty)
  );

  assign {b_ctl, b_sum, b_cnt, b_done, b_dc} = rec_out;

  wacrm_back #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS), .SUM_W(SUM_W)) u_back (
    .clk_i, .rst_ni,
    .rec_empty_i(rec_empty),
    .rec_rd_o   (rec_rd),
    .rec_sum_i  (b_sum),
    .rec_cnt_i  (b_cnt),
    .rec_done_i (b_done),
    .rec_dc_i   (b_dc),
    .rec_ctl_i  (b_ctl),
    .gain_i     (gain_q),
    .dc_valid_o (dc_valid),
    .dc_o       (dc),
    .empty, .pop, .out_o
  );
endmodule

@@ design/wacrm_checker.sv @@
// Port checker for the windowed AC RMS meter, bound to the top level.
// Depends on wacrm_pkg and windowed_ac_rms_meter_top.
module wacrm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            empty,
  input logic            pop,
  input wacrm_pkg::out_t out_o
);
  // a waiting reading holds while the receiver stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("reading changed while stalled");

  // the single result register refills no earlier than the next cycle
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop |=> empty)
    else $error("result register refilled in the pop cycle");

  // the reading never exceeds the saturation limit
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_o.rms_reading <= wacrm_pkg::OUT_MAX)
    else $error("reading above saturation limit");

  // no reading straight out of reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("reading present after reset");
endmodule

bind windowed_ac_rms_meter_top wacrm_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .out_o
);

@@ bench/windowed_ac_rms_meter_top_test.sv @@
// Self-checking bench for the windowed AC RMS meter: predicts each reading from the samples
// and compares it field by field. Depends on wacrm_pkg and windowed_ac_rms_meter_top.
`timescale 1ns / 100ps

module windowed_ac_rms_meter_top_test;

  localparam int unsigned CNT_MAX = 16'hFFFF;
  localparam int unsigned WATCH_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  wacrm_pkg::in_t in_i = '0;
  logic empty;
  logic pop = 1'b0;
  wacrm_pkg::out_t out_o;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = wacrm_pkg::CFG_WINDOWS;
  logic [wacrm_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  windowed_ac_rms_meter_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_i(in_i),
    .empty(empty), .pop(pop), .out_o(out_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  win_cfg = wacrm_pkg::WIN_RESET;
  logic [19:0] gain_cfg = wacrm_pkg::GAIN_RESET;
  logic        in_rms = 1'b0;
  logic [7:0]  win_idx = '0;
  logic [31:0] n_samples = '0;
  logic [63:0] acc_sum = '0;
  logic [11:0] offset_q = '0;
  logic [63:0] root_sum = '0;
  logic        ovf_q = 1'b0;

  wacrm_pkg::in_t  sample_q[$];
  wacrm_pkg::out_t reading_q[$];
  int   errors = 0;
  bit   stim_done = 1'b0;
  int   idle_cnt = 0;
  int   push_wait = 0;
  int   pop_wait = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // advance the predictor by one accepted sample
  task automatic predict_reading(wacrm_pkg::in_t it);
    logic [63:0] mean, root, scaled, avg, dev;
    logic [31:0] done, target;
    wacrm_pkg::out_t r;
    if (n_samples >= CNT_MAX) begin
      ovf_q = 1'b1;
    end else begin
      if (in_rms) begin
        dev = (it.sample >= offset_q) ? 64'(it.sample - offset_q) : 64'(offset_q - it.sample);
        acc_sum += dev * dev;
      end else begin
        acc_sum += 64'(it.sample);
      end
      n_samples++;
    end
    if (!it.window_end) return;
    mean = (n_samples != 0) ? acc_sum / 64'(n_samples) : 64'd0;
    acc_sum = '0;
    n_samples = '0;
    if (!in_rms) begin
      offset_q = mean[11:0];
      in_rms = 1'b1;
      win_idx = '0;
      return;
    end
    root = int_sqrt(mean << 16);
    scaled = (root * 64'(gain_cfg)) >> 16;
    root_sum += scaled;
    done = 32'(win_idx) + 1;
    target = (win_cfg != 0) ? 32'(win_cfg) : 32'd1;
    if (done < target) begin
      win_idx = done[7:0];
      return;
    end
    avg = (root_sum / 64'(done)) >> 8;
    if (avg > 64'(wacrm_pkg::OUT_MAX)) avg = 64'(wacrm_pkg::OUT_MAX);
    r.rms_reading = avg[11:0];
    r.zero_point = offset_q;
    r.overflow = ovf_q;
    reading_q.push_back(r);
    in_rms = 1'b0;
    win_idx = '0;
    root_sum = '0;
    ovf_q = 1'b0;
  endtask

  // driver: present pending samples with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_reading(in_i);
        push_wait = $urandom_range(0, 10);
      end
      if ((!push || !full) && push_wait > 0) begin
        push <= 1'b0;
        push_wait--;
      end else if (!push || !full) begin
        if (sample_q.size() > 0) begin
          in_i <= sample_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: pop readings with random stalls and check them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (reading_q.size() == 0) begin
          $display("%0t: unexpected reading expected none actual %p", $time, out_o);
          errors++;
        end else begin
          wacrm_pkg::out_t e;
          e = reading_q.pop_front();
          if (e.rms_reading !== out_o.rms_reading) begin
            $display("%0t: rms_reading expected %0d actual %0d", $time, e.rms_reading,
                     out_o.rms_reading);
            errors++;
          end
          if (e.zero_point !== out_o.zero_point) begin
            $display("%0t: zero_point expected %0d actual %0d", $time, e.zero_point,
                     out_o.zero_point);
            errors++;
          end
          if (e.overflow !== out_o.overflow) begin
            $display("%0t: overflow expected %0d actual %0d", $time, e.overflow,
                     out_o.overflow);
            errors++;
          end
        end
        pop_wait = $urandom_range(0, 10);
      end
      if (pop_wait > 0 && (!pop || !empty)) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog: count cycles with no request moving
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni || stim_done) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCH_LIMIT) begin
      $display("FAIL windowed_ac_rms_meter_top");
      $finish;
    end
  end

  // queue one window: offset-like or random-amplitude content
  task automatic add_window(int len, int lo, int hi);
    wacrm_pkg::in_t it;
    for (int k = 0; k < len; k++) begin
      it.sample = 12'($urandom_range(lo, hi));
      it.window_end = (k == len - 1);
      sample_q.push_back(it);
    end
  endtask

  task automatic add_measurement(int nwin);
    int c, a;
    c = $urandom_range(0, 4095);
    add_window($urandom_range(1, 8), c, c);
    for (int w = 0; w < nwin; w++) begin
      a = $urandom_range(0, 2047);
      add_window($urandom_range(1, 10), (c > a) ? c - a : 0, (c + a > 4095) ? 4095 : c + a);
    end
  endtask

  task automatic wait_idle();
    while (sample_q.size() > 0 || push || reading_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [wacrm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == wacrm_pkg::CFG_WINDOWS) win_cfg = val[7:0];
    else gain_cfg = val[19:0];
  endtask

  initial begin
    wacrm_pkg::in_t it;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes at reset settings
    it = '{sample: 12'd4095, window_end: 1'b1}; sample_q.push_back(it);
    for (int w = 0; w < 5; w++) begin
      it = '{sample: 12'd0, window_end: 1'b0}; sample_q.push_back(it);
      it = '{sample: 12'd4095, window_end: 1'b1}; sample_q.push_back(it);
    end
    it = '{sample: 12'd0, window_end: 1'b1}; sample_q.push_back(it);
    for (int w = 0; w < 5; w++) begin
      it = '{sample: 12'd4095, window_end: 1'b1}; sample_q.push_back(it);
    end
    wait_idle();
    // window count zero acts as one; maximum gain saturates
    write_reg(wacrm_pkg::CFG_WINDOWS, 20'd0);
    write_reg(wacrm_pkg::CFG_GAIN, 20'hFFFFF);
    add_measurement(1);
    add_measurement(1);
    wait_idle();
    write_reg(wacrm_pkg::CFG_GAIN, 20'd0);
    add_measurement(1);
    wait_idle();
    // random phases through several settings
    for (int ph = 0; ph < 8; ph++) begin
      int nw;
      int c;
      nw = (ph == 7) ? 255 : $urandom_range(1, 12);
      write_reg(wacrm_pkg::CFG_WINDOWS, 20'(nw));
      write_reg(wacrm_pkg::CFG_GAIN, (ph % 3 == 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                                   : 20'($urandom_range(20000, 200000)));
      if (ph == 7) begin
        // many short windows in one measurement
        c = $urandom_range(0, 4095);
        add_window(1, c, c);
        for (int w = 0; w < 255; w++) add_window($urandom_range(1, 2), 0, 4095);
      end else begin
        for (int m = 0; m < 2; m++) add_measurement(nw);
        // noise: stray window ends
        for (int k = 0; k < 10; k++) begin
          it.sample = 12'($urandom_range(0, 4095));
          it.window_end = 1'($urandom_range(0, 1));
          sample_q.push_back(it);
        end
        add_measurement(nw);
      end
      wait_idle();
    end
    stim_done = 1'b1;
    if (errors == 0) begin
      $display("PASS windowed_ac_rms_meter_top");
    end else begin
      $display("FAIL windowed_ac_rms_meter_top");
    end
    $finish;
  end
endmodule

@@ windowed_ac_rms_meter_top.f @@
design/wacrm_pkg.sv
design/wacrm_fifo.sv
design/wacrm_front.sv
design/wacrm_back.sv
design/windowed_ac_rms_meter_top.sv
design/wacrm_checker.sv
bench/windowed_ac_rms_meter_top_test.sv
